[rtl/hkv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkv_pkg
// shared types and constants of the hashed key-value table
// ----------------------------------------------------------------------------
package hkv_pkg;
   localparam logic [31:0] HASH_MUL = 32'h045d9f3b;
   localparam logic [4:0] COUNT_RESET = 5'd10;
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request
      logic mul1;      // first hash round
      logic mul2;      // second hash round
      logic fin;       // final xor, start modulo
      logic mod_step;  // one restoring subtract
      logic scan_step; // inspect one slot
      logic commit;    // apply update or remove, form result
   } hkv_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mod_done;
      logic scan_done;
   } hkv_sts_type;
endpackage

[rtl/hkv_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkv_ctrl
// sequencer for one request: hash, modulo, bucket scan, commit
// ----------------------------------------------------------------------------
module hkv_ctrl
   import hkv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_fire,
   output logic        busy,
   output logic        done,
   input  hkv_sts_type sts,
   output hkv_cmd_type cmd
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_MUL2 = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_MOD  = 3'd4;
   localparam logic [2:0] ST_SCAN = 3'd5;
   localparam logic [2:0] ST_COMM = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.load = req_fire;
      case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_MUL1;
         ST_MUL1: begin cmd.mul1 = 1'b1; state_in = ST_MUL2; end
         ST_MUL2: begin cmd.mul2 = 1'b1; state_in = ST_FIN; end
         ST_FIN:  begin cmd.fin = 1'b1; state_in = ST_MOD; end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_done) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = ST_COMM;
         end
         ST_COMM: begin cmd.commit = 1'b1; state_in = ST_IDLE; end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_COMM);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

[rtl/hkv_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkv_dp
// hash datapath, serial modulo and slot store
// ----------------------------------------------------------------------------
module hkv_dp
   import hkv_pkg::*;
#(
   parameter int NUM_BUCKETS      = 16,
   parameter int SLOTS_PER_BUCKET = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  hkv_cmd_type cmd,
   output hkv_sts_type sts,
   input  logic [4:0]  count,
   input  logic        req_op,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   output logic        res_success,
   output logic [3:0]  res_bucket
);
   localparam int TOTAL = NUM_BUCKETS * SLOTS_PER_BUCKET;
   localparam int SW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int IW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int CW = $clog2(NUM_BUCKETS + 1);
   localparam int RW = (CW > 5) ? CW : 5;

   logic        op_ff;
   logic [31:0] key_ff, val_ff, h_ff, h_in;
   logic [31:0] rem_ff;            // remainder in progress
   logic [5:0]  bit_ff;            // bits left to shift in
   logic [RW-1:0] eff;
   logic [RW:0] trial;
   logic [31:0] quo_ff;            // dividend bits still to shift
   logic [BW-1:0] bucket_ff;
   logic [IW:0] idx_ff;
   logic        hit_ff, free_ff;
   logic [SW-1:0] hit_slot_ff, free_slot_ff, cur;
   logic [TOTAL-1:0] valid_ff;
   logic [31:0] key_mem [TOTAL];
   logic [31:0] val_mem [TOTAL];
   logic [31:0] rd_key_ff;
   logic        rd_ok_ff;
   logic [SW-1:0] rd_slot_ff;

   // clamp register count to 1..NUM_BUCKETS
   always_comb begin
      eff = RW'(count);
      if (count == 5'd0) eff = RW'(1);
      if (RW'(count) > RW'(NUM_BUCKETS)) eff = RW'(NUM_BUCKETS);
   end

   assign h_in = cmd.mul1 ? ((key_ff >> 16) ^ key_ff) * HASH_MUL
                          : ((h_ff >> 16) ^ h_ff) * HASH_MUL;
   assign trial = {rem_ff[RW-1:0], quo_ff[31]} - {1'b0, eff};
   assign cur = SW'(SW'(bucket_ff) * SW'(SLOTS_PER_BUCKET) + SW'(idx_ff));

   assign sts.mod_done  = (bit_ff == 6'd1);
   assign sts.scan_done = (idx_ff == (IW+1)'(SLOTS_PER_BUCKET));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op; key_ff <= req_key; val_ff <= req_value;
      end
      if (cmd.mul1 || cmd.mul2) h_ff <= h_in;
      if (cmd.fin) begin
         quo_ff <= (h_ff >> 16) ^ h_ff;
         rem_ff <= '0;
         bit_ff <= 6'd32;
      end
      if (cmd.mod_step) begin
         quo_ff <= {quo_ff[30:0], 1'b0};
         bit_ff <= bit_ff - 6'd1;
         if (!trial[RW]) rem_ff <= 32'(trial[RW-1:0]);
         else rem_ff <= {rem_ff[30:0], quo_ff[31]};
         idx_ff <= '0;
         hit_ff <= 1'b0; free_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
      end
      if (cmd.mod_step && sts.mod_done)
         bucket_ff <= BW'(!trial[RW] ? trial[RW-1:0] : {rem_ff[RW-2:0], quo_ff[31]});
      // scan: read one slot per cycle, compare the previous read
      if (cmd.scan_step) begin
         if (!sts.scan_done) begin
            rd_key_ff  <= key_mem[cur];
            rd_slot_ff <= cur;
            idx_ff     <= idx_ff + (IW+1)'(1);
         end
         rd_ok_ff <= !sts.scan_done;
         if (rd_ok_ff) begin
            if (valid_ff[rd_slot_ff]) begin
               if (!hit_ff && rd_key_ff == key_ff) begin
                  hit_ff <= 1'b1; hit_slot_ff <= rd_slot_ff;
               end
            end else if (!free_ff) begin
               free_ff <= 1'b1; free_slot_ff <= rd_slot_ff;
            end
         end
      end
      if (cmd.commit) begin
         if (op_ff == OP_UPDATE) begin
            if (hit_ff) begin
               val_mem[hit_slot_ff] <= val_ff;
            end else if (free_ff) begin
               key_mem[free_slot_ff] <= key_ff;
               val_mem[free_slot_ff] <= val_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         if (op_ff == OP_UPDATE && !hit_ff && free_ff) valid_ff[free_slot_ff] <= 1'b1;
         if (op_ff == OP_REMOVE && hit_ff) valid_ff[hit_slot_ff] <= 1'b0;
      end
   end

   // scan flags are final during the commit cycle
   assign res_success = (op_ff == OP_UPDATE) ? (hit_ff || free_ff) : hit_ff;
   assign res_bucket  = res_success ? 4'(bucket_ff) : 4'd0;
endmodule

[rtl/hashed_key_value_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_key_value_table_top
// key-value table with integer hash over a bucketed slot store
// ----------------------------------------------------------------------------
// channel   dir   contents
// req       in    tdata {value, key, op}, op in bit 0
// rsp       out   tdata {bucket_index, success}, success in bit 0
// csr       in    bucket count write, 5 bits
//
// one request at a time; steps from acceptance to the response
// handshake: two hash multiply rounds, a final xor, a 32-step restoring
// modulo, a bucket scan, a commit, then the registered response
// the serial modulo dominates the latency
// reset clears the valid marks at once, no clearing pass
// a waiting response blocks the next request; the next request can be taken
// in the cycle the response is taken
// ----------------------------------------------------------------------------
module hashed_key_value_table_top
   import hkv_pkg::*;
#(
   parameter int NUM_BUCKETS      = 16,
   parameter int SLOTS_PER_BUCKET = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // op[0], key[32:1], value[64:33], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // success[0], bucket_index[4:1], zero pad
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);
   hkv_cmd_type cmd;
   hkv_sts_type sts;
   logic busy, done, res_success, req_fire;
   logic [3:0] res_bucket;
   logic [4:0] count_ff;
   logic rsp_valid_ff;
   logic [4:0] rsp_data_ff;

   // accept while idle and the response slot is free or being drained
   assign req_tready = !busy && (!rsp_valid_ff || rsp_tready);
   assign req_fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) count_ff <= csr_wdata;
         if (done) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (done) rsp_data_ff <= {res_bucket, res_success};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000, rsp_data_ff};

   hkv_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .busy(busy), .done(done), .sts(sts), .cmd(cmd)
   );

   hkv_dp #(
      .NUM_BUCKETS(NUM_BUCKETS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .count(count_ff), .req_op(req_tdata[0]), .req_key(req_tdata[32:1]),
      .req_value(req_tdata[64:33]), .res_success(res_success),
      .res_bucket(res_bucket)
   );
endmodule

[rtl/hkv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkv_checker
// port-level checks of the key-value table
// ----------------------------------------------------------------------------
module hkv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   // a failed response carries bucket zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[4:1] == 4'd0) else $error("fail bucket");
   // pad bits stay zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:5] == 3'd0) else $error("pad");
   // no new request right after one was taken
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("overlap");
   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("hold");
endmodule

bind hashed_key_value_table_top hkv_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

[sim/hashed_key_value_table_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_key_value_table_top_test
// self-checking bench for the hashed key-value table: a local copy of the
// table predicts success and bucket of every request, responses are
// compared in order under several idle and stall patterns
// ----------------------------------------------------------------------------
module hashed_key_value_table_top_test;
   import hkv_pkg::*;

   localparam int NB = 16;
   localparam int SPB = 4;
   localparam int TOTAL = NB * SPB;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic       success;
      logic [3:0] bucket;
   } lookup_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_we = 1'b0;
   logic [4:0]  csr_wdata = '0;

   // predicted table contents
   logic [4:0]  model_count;
   logic        tbl_valid [TOTAL];
   logic [31:0] tbl_key [TOTAL];
   logic [31:0] tbl_value [TOTAL];

   lookup_result_type pending_results[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;   // chance per cycle that the sender waits
   int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
   int hold_off = 0;        // long receiver hold-off, in cycles
   logic [31:0] recent_keys [8];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   hashed_key_value_table_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // xor-shift-multiply hash of the key
   function automatic logic [31:0] key_hash(logic [31:0] k);
      logic [31:0] h;
      h = ((k >> 16) ^ k) * HASH_MUL;
      h = ((h >> 16) ^ h) * HASH_MUL;
      return (h >> 16) ^ h;
   endfunction

   // apply one request to the local table, return its response
   function automatic lookup_result_type apply_request(logic op, logic [31:0] k,
                                                       logic [31:0] v);
      int cnt;
      int bkt;
      int hit;
      int free_slot;
      lookup_result_type r;
      cnt = model_count;
      if (cnt == 0) cnt = 1;           // zero count acts as one
      if (cnt > NB) cnt = NB;          // oversize count clamps
      bkt = key_hash(k) % cnt;
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < SPB; i++) begin
         if (tbl_valid[bkt*SPB+i]) begin
            if (hit < 0 && tbl_key[bkt*SPB+i] == k) hit = bkt*SPB+i;
         end else if (free_slot < 0) begin
            free_slot = bkt*SPB+i;
         end
      end
      r.success = 1'b0;
      if (op == OP_UPDATE) begin
         if (hit >= 0) begin
            tbl_value[hit] = v;
            r.success = 1'b1;
         end else if (free_slot >= 0) begin
            tbl_valid[free_slot] = 1'b1;
            tbl_key[free_slot] = k;
            tbl_value[free_slot] = v;
            r.success = 1'b1;
         end
      end else if (hit >= 0) begin
         tbl_valid[hit] = 1'b0;
         r.success = 1'b1;
      end
      r.bucket = r.success ? bkt[3:0] : 4'd0;
      return r;
   endfunction

   // offer one request, predict it once accepted
   task automatic send_request(logic op, logic [31:0] k, logic [31:0] v);
      do @(negedge clock);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct);
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, v, k, op};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(apply_request(op, k, v));
      recent_keys[$urandom_range(7)] = k;
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // wait until every response is back, then let the block settle
   task automatic drain;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_count(logic [4:0] c);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= c;
      @(negedge clock);
      csr_we <= 1'b0;
      model_count = c;
   endtask

   // receiver: random stalls and an optional long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      lookup_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.success = rsp_tdata[0];
         got.bucket  = rsp_tdata[4:1];
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (got !== want || rsp_tdata[7:5] !== 3'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected success %b bucket %0d, got %b %0d",
                           want.success, want.bucket, got.success, got.bucket);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** hashed_key_value_table_top: FAILED **");
            $finish;
         end
      end
   end

   // directed: field extremes, replace, remove miss, full bucket
   task automatic test_directed;
      send_request(OP_UPDATE, 32'h00000000, 32'h80000000);
      send_request(OP_UPDATE, 32'hffffffff, 32'h7fffffff);
      send_request(OP_UPDATE, 32'h80000000, 32'hffffffff);
      send_request(OP_UPDATE, 32'h7fffffff, 32'h00000000);
      send_request(OP_UPDATE, 32'h00000000, 32'h12345678);  // replace
      send_request(OP_REMOVE, 32'h00000000, 32'hffffffff);
      send_request(OP_REMOVE, 32'h00000000, 32'h0);         // already gone
      send_request(OP_REMOVE, 32'h5555aaaa, 32'h0);         // never stored
      // single bucket: six new keys overflow the four slots
      write_count(5'd1);
      for (int i = 1; i <= 6; i++) send_request(OP_UPDATE, i, ~i);
      send_request(OP_UPDATE, 32'd2, 32'd99);
      send_request(OP_REMOVE, 32'd3, 32'd0);
      send_request(OP_UPDATE, 32'd6, 32'd6);
   endtask

   // count extremes: zero, maximum and oversize
   task automatic test_count_extremes;
      write_count(5'd0);
      for (int i = 0; i < 6; i++) send_request(OP_UPDATE, 32'h100 + i, i);
      write_count(5'd16);
      for (int i = 0; i < 6; i++) send_request(OP_UPDATE, 32'h100 + i, i);
      write_count(5'd31);
      for (int i = 0; i < 6; i++) send_request(OP_REMOVE, 32'h100 + i, 0);
   endtask

   task automatic random_phase(int n, logic [4:0] cnt);
      logic [31:0] k;
      write_count(cnt);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: k = $urandom();
            1: k = $urandom_range(40);
            default: k = recent_keys[$urandom_range(7)];
         endcase
         send_request($urandom_range(99) < 60 ? OP_UPDATE : OP_REMOVE,
                      k, $urandom());
      end
   endtask

   task automatic test_random;
      random_phase(150, 5'd10);
      send_idle_pct = 86;
      random_phase(150, 5'd3);
      send_idle_pct = 0;
      recv_stall_pct = 86;
      random_phase(150, 5'd16);
      send_idle_pct = 36;
      recv_stall_pct = 36;
      random_phase(150, 5'd7);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_phase(240, 5'($urandom_range(31)));
      send_idle_pct = 36;
      random_phase(240, 5'd2);
      recv_stall_pct = 86;
      send_idle_pct = 0;
      random_phase(240, 5'd12);
      recv_stall_pct = 0;
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_backpressure;
      drain();
      hold_off = 400;
      random_phase(40, 5'd9);
   endtask

   initial begin
      model_count = COUNT_RESET;
      for (int i = 0; i < TOTAL; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_key[i] = '0;
         tbl_value[i] = '0;
      end
      for (int i = 0; i < 8; i++) recent_keys[i] = i;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_count_extremes();
      test_backpressure();
      test_random();
      drain();
      if (mismatches == 0 && pending_results.size() == 0)
         $display("** hashed_key_value_table_top: PASSED **");
      else
         $display("** hashed_key_value_table_top: FAILED **");
      $finish;
   end
endmodule

[files.f]
rtl/hkv_pkg.sv
rtl/hkv_ctrl.sv
rtl/hkv_dp.sv
rtl/hashed_key_value_table_top.sv
rtl/hkv_checker.sv
sim/hashed_key_value_table_top_test.sv
